// ----- design/mcod_pkg.sv -----
// Shared types, sizes and helpers for the matrix chain order engine.
package mcod_pkg;

    localparam int MAX_MATRICES = 8;
    localparam int NDIMS        = MAX_MATRICES + 1;
    localparam int CELLS        = MAX_MATRICES * MAX_MATRICES;

    localparam int DIM_W    = 12;
    localparam int COST_W   = 40;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 2;

    localparam int CNT_W   = $clog2(NDIMS + 1);
    localparam int DADDR_W = $clog2(NDIMS);
    localparam int CADDR_W = $clog2(CELLS);
    localparam int LIN_W   = IDX_W + CADDR_W;
    localparam int ENTRY_W = COST_W + IDX_W;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } res_status_t;

    typedef struct packed {
        logic [DIM_W-1:0] dim_value;
        logic             last_dim;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]    row_index;
        logic [IDX_W-1:0]    col_index;
        logic [COST_W-1:0]   min_cost;
        logic [IDX_W-1:0]    split_point;
        logic [STATUS_W-1:0] status;
        logic                last_result;
    } out_item_t;

    typedef struct packed {
        logic               dim_wr;
        logic [DADDR_W-1:0] dim_waddr;
        logic               setup_rd;
        logic               issue;
        logic               latch;
        logic               k_first;
        logic               k_last;
        logic               diag_wr;
        logic               emit_rd;
        logic               emit_empty;
        logic               emit_last;
        res_status_t        status;
        logic [IDX_W-1:0]   row;
        logic [IDX_W-1:0]   col;
        logic [IDX_W-1:0]   split_k;
    } cmd_t;

    typedef struct packed {
        logic cell_done;
        logic emit_ready;
    } stat_t;

    function automatic logic [CADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                     input logic [IDX_W-1:0] col);
        logic [LIN_W-1:0] lin;
        lin = (LIN_W'(row) - LIN_W'(1)) * LIN_W'(MAX_MATRICES) + LIN_W'(col) - LIN_W'(1);
        return lin[CADDR_W-1:0];
    endfunction

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
    endfunction

endpackage

// ----- design/matrix_chain_order_dp_core.sv -----
// Top level of the matrix chain order engine: sequencer plus datapath.
// Feed the chain one dimension per item; the item with last_dim set closes it.
// Up to MAX_MATRICES+1 dimensions are kept; extra dimensions are dropped and
// every result of that run reports status 1. After the closing item the block
// fills the cost and split tables, each entry i<j through the five-stage read,
// two-multiply, add and compare pipeline that takes one split point per cycle,
// then emits all entries i<=j in row order; a new table read waits until the
// previous result, from the table memory's registered read port, is loaded
// into the result register, and while a held result is stalled.
// A chain of one dimension gives a single result with status 2. Input items
// are stalled from the closing item until the last result read is issued.
module matrix_chain_order_dp_core
    import mcod_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      dim_valid,
    output logic      dim_stall,
    input  in_item_t  dim_item,
    output logic      res_valid,
    input  logic      res_stall,
    output out_item_t res_item
);

    cmd_t  cmd;
    stat_t stat;

    mcod_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .dim_valid (dim_valid),
        .last_dim  (dim_item.last_dim),
        .dim_stall (dim_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    mcod_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .dim_value (dim_item.dim_value),
        .cmd       (cmd),
        .stat      (stat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

endmodule

// ----- design/mcod_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
module mcod_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- design/mcod_ctrl.sv -----
// Sequencer: chain loading, table fill order and result emission order.
module mcod_ctrl
    import mcod_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  dim_valid,
    input  logic  last_dim,
    output logic  dim_stall,
    output cmd_t  cmd,
    input  stat_t stat
);

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_DIAG  = 7'b0000010,
        S_SETUP = 7'b0000100,
        S_ISSUE = 7'b0001000,
        S_WAIT  = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_EMPTY = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic [IDX_W-1:0] n_reg, n_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;

    logic             has_room;
    logic [CNT_W-1:0] cnt_after;

    assign has_room  = (cnt_reg < CNT_W'(NDIMS));
    assign cnt_after = has_room ? (cnt_reg + CNT_W'(1)) : cnt_reg;
    assign dim_stall = (state_reg != S_LOAD);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;

        cmd           = '0;
        cmd.dim_waddr = DADDR_W'(cnt_reg);
        cmd.status    = ovf_reg ? ST_OVERFLOW : ST_OK;
        cmd.row       = i_reg;
        cmd.col       = j_reg;
        cmd.split_k   = k_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (dim_valid)
                begin
                    if (has_room)
                    begin
                        cmd.dim_wr = 1'b1;
                        cnt_next   = cnt_after;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_dim)
                    begin
                        if (cnt_after <= CNT_W'(1))
                        begin
                            state_next = S_EMPTY;
                        end
                        else
                        begin
                            n_next     = IDX_W'(cnt_after - CNT_W'(1));
                            i_next     = IDX_W'(cnt_after - CNT_W'(1));
                            state_next = S_DIAG;
                        end
                    end
                end
            end
            S_DIAG:
            begin
                cmd.diag_wr = 1'b1;
                if (i_reg == n_reg)
                begin
                    if (i_reg == IDX_W'(1))
                    begin
                        i_next     = IDX_W'(1);
                        j_next     = IDX_W'(1);
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        i_next = i_reg - IDX_W'(1);
                    end
                end
                else
                begin
                    j_next     = i_reg + IDX_W'(1);
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup_rd = 1'b1;
                k_next       = i_reg;
                state_next   = S_ISSUE;
            end
            S_ISSUE:
            begin
                cmd.issue   = 1'b1;
                cmd.k_first = (k_reg == i_reg);
                cmd.latch   = (k_reg == i_reg);
                cmd.k_last  = (k_reg == j_reg - IDX_W'(1));
                k_next      = k_reg + IDX_W'(1);
                if (cmd.k_last)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (stat.cell_done)
                begin
                    if (j_reg == n_reg)
                    begin
                        if (i_reg == IDX_W'(1))
                        begin
                            i_next     = IDX_W'(1);
                            j_next     = IDX_W'(1);
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            i_next     = i_reg - IDX_W'(1);
                            state_next = S_DIAG;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + IDX_W'(1);
                        state_next = S_SETUP;
                    end
                end
            end
            S_EMIT:
            begin
                if (stat.emit_ready)
                begin
                    cmd.emit_rd   = 1'b1;
                    cmd.emit_last = (i_reg == n_reg) && (j_reg == n_reg);
                    if (cmd.emit_last)
                    begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else if (j_reg == n_reg)
                    begin
                        i_next = i_reg + IDX_W'(1);
                        j_next = i_reg + IDX_W'(1);
                    end
                    else
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
            end
            S_EMPTY:
            begin
                if (stat.emit_ready)
                begin
                    cmd.emit_rd    = 1'b1;
                    cmd.emit_empty = 1'b1;
                    cmd.emit_last  = 1'b1;
                    cnt_next       = '0;
                    ovf_next       = 1'b0;
                    state_next     = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            n_reg     <= n_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    a_issue_k_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (k_reg >= i_reg) && (k_reg < j_reg) && (j_reg <= n_reg))
        else $error("split index outside subchain");

    a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        stat.cell_done |-> (state_reg == S_WAIT))
        else $error("cell write outside wait");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(NDIMS))
        else $error("dimension count beyond capacity");

endmodule

// ----- design/mcod_dp.sv -----
// Datapath: dimension and table memories, split-point pipeline, result register.
module mcod_dp
    import mcod_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [DIM_W-1:0] dim_value,
    input  cmd_t             cmd,
    output stat_t            stat,
    output logic             res_valid,
    input  logic             res_stall,
    output out_item_t        res_item
);

    logic [DIM_W-1:0]   dim_q_a, dim_q_b;
    logic [DADDR_W-1:0] dim_raddr_a;
    logic [ENTRY_W-1:0] cost_q_a, cost_q_b;
    logic [CADDR_W-1:0] cost_waddr, cost_raddr_a, cost_raddr_b;
    logic [ENTRY_W-1:0] cost_wdata;
    logic               cost_we;

    logic [DIM_W-1:0]     di_reg, dj_reg;
    logic                 s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic                 s1_first_reg, s2_first_reg, s3_first_reg, s4_first_reg;
    logic                 s1_last_reg, s2_last_reg, s3_last_reg, s4_last_reg;
    logic [IDX_W-1:0]     s1_k_reg, s2_k_reg, s3_k_reg, s4_k_reg;
    logic [2*DIM_W-1:0]   m1_reg;
    logic [COST_W-1:0]    sab2_reg, sab3_reg;
    logic [3*DIM_W-1:0]   prod_reg;
    logic [COST_W-1:0]    q_reg;
    logic [COST_W-1:0]    best_reg;
    logic [IDX_W-1:0]     bestk_reg;
    logic                 done_reg;

    logic                 pend_reg;
    logic [IDX_W-1:0]     m_row_reg, m_col_reg;
    res_status_t          m_status_reg;
    logic                 m_last_reg, m_empty_reg;
    logic                 res_valid_reg, res_valid_next;
    out_item_t            res_item_reg;

    assign dim_raddr_a = cmd.setup_rd ? DADDR_W'(cmd.row - IDX_W'(1)) : DADDR_W'(cmd.split_k);

    mcod_ram #(.WIDTH(DIM_W), .DEPTH(NDIMS)) u_dim_ram (
        .clk     (clk),
        .we      (cmd.dim_wr),
        .waddr   (cmd.dim_waddr),
        .wdata   (dim_value),
        .raddr_a (dim_raddr_a),
        .rdata_a (dim_q_a),
        .raddr_b (DADDR_W'(cmd.col)),
        .rdata_b (dim_q_b)
    );

    assign cost_we      = cmd.diag_wr | done_reg;
    assign cost_waddr   = done_reg ? cell_addr(cmd.row, cmd.col) : cell_addr(cmd.row, cmd.row);
    assign cost_wdata   = done_reg ? {best_reg, bestk_reg} : '0;
    assign cost_raddr_a = cmd.emit_rd ? cell_addr(cmd.row, cmd.col)
                                      : cell_addr(cmd.row, cmd.split_k);
    assign cost_raddr_b = cell_addr(cmd.split_k + IDX_W'(1), cmd.col);

    mcod_ram #(.WIDTH(ENTRY_W), .DEPTH(CELLS)) u_cost_ram (
        .clk     (clk),
        .we      (cost_we),
        .waddr   (cost_waddr),
        .wdata   (cost_wdata),
        .raddr_a (cost_raddr_a),
        .rdata_a (cost_q_a),
        .raddr_b (cost_raddr_b),
        .rdata_b (cost_q_b)
    );

    // split-point pipeline: read, first product, second product, sum, compare
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= cmd.issue;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            done_reg   <= s4_vld_reg & s4_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            di_reg <= dim_q_a;
            dj_reg <= dim_q_b;
        end
        s1_first_reg <= cmd.k_first;
        s1_last_reg  <= cmd.k_last;
        s1_k_reg     <= cmd.split_k;

        m1_reg       <= (2*DIM_W)'(di_reg) * (2*DIM_W)'(dim_q_a);
        sab2_reg     <= sat_add(cost_q_a[ENTRY_W-1 -: COST_W], cost_q_b[ENTRY_W-1 -: COST_W]);
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_k_reg     <= s1_k_reg;

        prod_reg     <= (3*DIM_W)'(m1_reg) * (3*DIM_W)'(dj_reg);
        sab3_reg     <= sab2_reg;
        s3_first_reg <= s2_first_reg;
        s3_last_reg  <= s2_last_reg;
        s3_k_reg     <= s2_k_reg;

        q_reg        <= sat_add(sab3_reg, COST_W'(prod_reg));
        s4_first_reg <= s3_first_reg;
        s4_last_reg  <= s3_last_reg;
        s4_k_reg     <= s3_k_reg;

        if (s4_vld_reg && (s4_first_reg || (q_reg < best_reg)))
        begin
            best_reg  <= q_reg;
            bestk_reg <= s4_k_reg;
        end
    end

    // result register, loaded in the cycle after the table read is issued
    assign res_valid_next = pend_reg | (res_valid_reg & res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= cmd.emit_rd;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_rd)
        begin
            m_row_reg    <= cmd.row;
            m_col_reg    <= cmd.col;
            m_status_reg <= cmd.emit_empty ? ST_EMPTY : cmd.status;
            m_last_reg   <= cmd.emit_last;
            m_empty_reg  <= cmd.emit_empty;
        end
        if (pend_reg)
        begin
            res_item_reg.row_index   <= m_empty_reg ? '0 : m_row_reg;
            res_item_reg.col_index   <= m_empty_reg ? '0 : m_col_reg;
            res_item_reg.min_cost    <= m_empty_reg ? '0 : cost_q_a[ENTRY_W-1 -: COST_W];
            res_item_reg.split_point <= m_empty_reg ? '0 : cost_q_a[IDX_W-1:0];
            res_item_reg.status      <= m_status_reg;
            res_item_reg.last_result <= m_last_reg;
        end
    end

    assign stat.cell_done  = done_reg;
    assign stat.emit_ready = ~pend_reg & (~res_valid_reg | ~res_stall);
    assign res_valid       = res_valid_reg;
    assign res_item        = res_item_reg;

    a_load_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !res_valid_reg)
        else $error("result loaded over a held item");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("cell written twice");

    a_write_port_free: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !cmd.diag_wr && !cmd.issue)
        else $error("table write port conflict");

endmodule
